/* sv/hotkey_autorepeat_level_control_unit_assert.svh */
// Assertion helpers used by the checker file.
`ifndef HOTKEY_AUTOREPEAT_LEVEL_CONTROL_UNIT_ASSERT_SVH
`define HOTKEY_AUTOREPEAT_LEVEL_CONTROL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HKAR_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HKAR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/hkar_pkg.sv */
`default_nettype none
package hkar_pkg;

    localparam int unsigned KEY_W   = 10;
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned MS_W    = 32;
    localparam int unsigned CFG_W   = 10;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [MS_W-1:0] FIRST_DELAY_MS = 32'd300;
    localparam logic [MS_W-1:0] REPEAT_MS      = 32'd100;
    localparam logic [MS_W-1:0] STALE_GAP_MS   = 32'd1000;

    localparam logic [LEVEL_W-1:0] VOLUME_FLOOR     = 8'd0;
    localparam logic [LEVEL_W-1:0] BRIGHTNESS_FLOOR = 8'd0;

    localparam logic [LEVEL_W-1:0] VOLUME_CEILING_RST     = 8'd20;
    localparam logic [LEVEL_W-1:0] BRIGHTNESS_CEILING_RST = 8'd10;

    typedef enum logic [1:0] {
        OP_POLL_START = 2'd0,
        OP_KEY_EVENT  = 2'd1,
        OP_POLL_END   = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMBO_MODE   = 3'd0,
        CFG_MODIFIER_KEY = 3'd1,
        CFG_SELECT_KEY   = 3'd2,
        CFG_UP_KEY       = 3'd3,
        CFG_DOWN_KEY     = 3'd4,
        CFG_VOL_CEILING  = 3'd5,
        CFG_BRT_CEILING  = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        TGT_NONE       = 2'd0,
        TGT_VOLUME     = 2'd1,
        TGT_BRIGHTNESS = 2'd2
    } target_t;

    // Step request for one level during a poll end
    typedef struct packed {
        logic up;
        logic down;
    } level_cmd_t;

endpackage
`default_nettype wire

/* sv/hkar_level_step.sv */
`default_nettype none
module hkar_level_step
    import hkar_pkg::*;
(
    input  wire level_cmd_t         cmd,
    input  wire logic [LEVEL_W-1:0] level,
    input  wire logic [LEVEL_W-1:0] ceiling,
    input  wire logic [LEVEL_W-1:0] floor_level,
    output logic      [LEVEL_W-1:0] level_next,
    output logic                    moved
);

    logic [LEVEL_W-1:0] mid;
    logic               up_done;
    logic               down_done;

    // Up step first, then the down step sees the raised level
    always_comb
    begin
        up_done   = cmd.up && (level < ceiling);
        mid       = up_done ? level + 8'd1 : level;
        down_done = cmd.down && (mid > floor_level);
        level_next = down_done ? mid - 8'd1 : mid;
        moved     = up_done || down_done;
    end

endmodule
`default_nettype wire

/* sv/hotkey_autorepeat_level_control_unit.sv */
// Result path: a poll-end transaction passes through the input register, then the
// result register; other operations give no result.
// Throughput: one transaction per cycle; a stalled result holds back only a
// following poll end waiting in the input register.
// Reset (rst_n, asynchronous, active low): levels to their floors, key state,
// timing and configuration to their defaults, both stages empty.
`default_nettype none
module hotkey_autorepeat_level_control_unit
    import hkar_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           operation,
    input  wire logic [KEY_W-1:0]     key_code,
    input  wire logic [1:0]           key_value,
    input  wire logic [MS_W-1:0]      time_ms,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [LEVEL_W-1:0]        volume_level,
    output logic [LEVEL_W-1:0]        brightness_level,
    output logic                      volume_moved,
    output logic                      brightness_moved
);

    // configuration
    logic               combo_mode_reg;
    logic [KEY_W-1:0]   modifier_key_reg;
    logic [KEY_W-1:0]   select_key_reg;
    logic [KEY_W-1:0]   up_key_reg;
    logic [KEY_W-1:0]   down_key_reg;
    logic [LEVEL_W-1:0] vol_ceiling_reg;
    logic [LEVEL_W-1:0] brt_ceiling_reg;

    // input stage
    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [KEY_W-1:0]  s1_code_reg;
    logic              s1_held_reg;
    logic [MS_W-1:0]   s1_time_reg;

    // block state
    logic [LEVEL_W-1:0] volume_reg, volume_next;
    logic [LEVEL_W-1:0] brightness_reg, brightness_next;
    logic               mod_held_reg, mod_held_next;
    logic               sel_held_reg, sel_held_next;
    logic               up_held_reg, up_held_next;
    logic               up_fresh_reg, up_fresh_next;
    logic [MS_W-1:0]    up_due_reg, up_due_next;
    logic               down_held_reg, down_held_next;
    logic               down_fresh_reg, down_fresh_next;
    logic [MS_W-1:0]    down_due_reg, down_due_next;
    logic [MS_W-1:0]    cur_ms_reg, cur_ms_next;
    logic [MS_W-1:0]    prev_poll_reg, prev_poll_next;
    logic               stale_reg, stale_next;

    // result stage
    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] out_vol_reg;
    logic [LEVEL_W-1:0] out_brt_reg;
    logic               out_vmov_reg;
    logic               out_bmov_reg;

    logic               s1_is_end;
    logic               s1_advance;
    logic               in_take;
    logic [MS_W-1:0]    gap_ms;
    logic               up_go;
    logic               down_go;
    target_t            target;
    level_cmd_t         vol_cmd;
    level_cmd_t         brt_cmd;
    logic [LEVEL_W-1:0] vol_stepped;
    logic [LEVEL_W-1:0] brt_stepped;
    logic               vol_moved_c;
    logic               brt_moved_c;

    // A poll end in the input stage waits only while the result register is full and not being read
    assign s1_is_end  = s1_valid_reg && (s1_op_reg == OP_POLL_END);
    assign s1_advance = s1_valid_reg && (!s1_is_end || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_take    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            combo_mode_reg   <= 1'b0;
            modifier_key_reg <= '0;
            select_key_reg   <= '0;
            up_key_reg       <= '0;
            down_key_reg     <= '0;
            vol_ceiling_reg  <= VOLUME_CEILING_RST;
            brt_ceiling_reg  <= BRIGHTNESS_CEILING_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_COMBO_MODE:   combo_mode_reg   <= cfg_data[0];
                CFG_MODIFIER_KEY: modifier_key_reg <= cfg_data;
                CFG_SELECT_KEY:   select_key_reg   <= cfg_data;
                CFG_UP_KEY:       up_key_reg       <= cfg_data;
                CFG_DOWN_KEY:     down_key_reg     <= cfg_data;
                CFG_VOL_CEILING:  vol_ceiling_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_BRT_CEILING:  brt_ceiling_reg  <= cfg_data[LEVEL_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg   <= op_t'(operation);
            s1_code_reg <= key_code;
            s1_held_reg <= |key_value;
            s1_time_reg <= time_ms;
        end
    end

    assign gap_ms = s1_time_reg - prev_poll_reg;

    always_comb
    begin
        if (combo_mode_reg)
        begin
            target = mod_held_reg ? TGT_BRIGHTNESS : (sel_held_reg ? TGT_VOLUME : TGT_NONE);
        end
        else
        begin
            target = mod_held_reg ? TGT_BRIGHTNESS : TGT_VOLUME;
        end
    end

    // A stale poll has its key state cleared, so no step fires
    assign up_go   = !stale_reg && (up_fresh_reg || (up_held_reg && (cur_ms_reg >= up_due_reg)));
    assign down_go = !stale_reg
                     && (down_fresh_reg || (down_held_reg && (cur_ms_reg >= down_due_reg)));

    assign vol_cmd.up   = up_go && (target == TGT_VOLUME);
    assign vol_cmd.down = down_go && (target == TGT_VOLUME);
    assign brt_cmd.up   = up_go && (target == TGT_BRIGHTNESS);
    assign brt_cmd.down = down_go && (target == TGT_BRIGHTNESS);

    hkar_level_step u_vol_step (
        .cmd         (vol_cmd),
        .level       (volume_reg),
        .ceiling     (vol_ceiling_reg),
        .floor_level (VOLUME_FLOOR),
        .level_next  (vol_stepped),
        .moved       (vol_moved_c)
    );

    hkar_level_step u_brt_step (
        .cmd         (brt_cmd),
        .level       (brightness_reg),
        .ceiling     (brt_ceiling_reg),
        .floor_level (BRIGHTNESS_FLOOR),
        .level_next  (brt_stepped),
        .moved       (brt_moved_c)
    );

    always_comb
    begin
        volume_next     = volume_reg;
        brightness_next = brightness_reg;
        mod_held_next   = mod_held_reg;
        sel_held_next   = sel_held_reg;
        up_held_next    = up_held_reg;
        up_fresh_next   = up_fresh_reg;
        up_due_next     = up_due_reg;
        down_held_next  = down_held_reg;
        down_fresh_next = down_fresh_reg;
        down_due_next   = down_due_reg;
        cur_ms_next     = cur_ms_reg;
        prev_poll_next  = prev_poll_reg;
        stale_next      = stale_reg;
        if (s1_advance)
        begin
            case (s1_op_reg)
                OP_POLL_START:
                begin
                    cur_ms_next = s1_time_reg;
                    if (gap_ms > STALE_GAP_MS)
                    begin
                        stale_next = 1'b1;
                    end
                end
                OP_KEY_EVENT:
                begin
                    // first match wins: modifier, select, up, down
                    if (!stale_reg)
                    begin
                        if (s1_code_reg == modifier_key_reg)
                        begin
                            mod_held_next = s1_held_reg;
                        end
                        else if (combo_mode_reg && (s1_code_reg == select_key_reg))
                        begin
                            sel_held_next = s1_held_reg;
                        end
                        else if (s1_code_reg == up_key_reg)
                        begin
                            up_held_next  = s1_held_reg;
                            up_fresh_next = s1_held_reg;
                            if (s1_held_reg)
                            begin
                                up_due_next = cur_ms_reg + FIRST_DELAY_MS;
                            end
                        end
                        else if (s1_code_reg == down_key_reg)
                        begin
                            down_held_next  = s1_held_reg;
                            down_fresh_next = s1_held_reg;
                            if (s1_held_reg)
                            begin
                                down_due_next = cur_ms_reg + FIRST_DELAY_MS;
                            end
                        end
                    end
                end
                OP_POLL_END:
                begin
                    prev_poll_next  = cur_ms_reg;
                    stale_next      = 1'b0;
                    volume_next     = vol_stepped;
                    brightness_next = brt_stepped;
                    if (stale_reg)
                    begin
                        mod_held_next   = 1'b0;
                        sel_held_next   = 1'b0;
                        up_held_next    = 1'b0;
                        up_fresh_next   = 1'b0;
                        up_due_next     = '0;
                        down_held_next  = 1'b0;
                        down_fresh_next = 1'b0;
                        down_due_next   = '0;
                    end
                    else
                    begin
                        if (up_go)
                        begin
                            if (up_fresh_reg)
                            begin
                                up_fresh_next = 1'b0;
                            end
                            else
                            begin
                                up_due_next = up_due_reg + REPEAT_MS;
                            end
                        end
                        if (down_go)
                        begin
                            if (down_fresh_reg)
                            begin
                                down_fresh_next = 1'b0;
                            end
                            else
                            begin
                                down_due_next = down_due_reg + REPEAT_MS;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg     <= VOLUME_FLOOR;
            brightness_reg <= BRIGHTNESS_FLOOR;
            mod_held_reg   <= 1'b0;
            sel_held_reg   <= 1'b0;
            up_held_reg    <= 1'b0;
            up_fresh_reg   <= 1'b0;
            up_due_reg     <= '0;
            down_held_reg  <= 1'b0;
            down_fresh_reg <= 1'b0;
            down_due_reg   <= '0;
            cur_ms_reg     <= '0;
            prev_poll_reg  <= '0;
            stale_reg      <= 1'b0;
        end
        else
        begin
            volume_reg     <= volume_next;
            brightness_reg <= brightness_next;
            mod_held_reg   <= mod_held_next;
            sel_held_reg   <= sel_held_next;
            up_held_reg    <= up_held_next;
            up_fresh_reg   <= up_fresh_next;
            up_due_reg     <= up_due_next;
            down_held_reg  <= down_held_next;
            down_fresh_reg <= down_fresh_next;
            down_due_reg   <= down_due_next;
            cur_ms_reg     <= cur_ms_next;
            prev_poll_reg  <= prev_poll_next;
            stale_reg      <= stale_next;
        end
    end

    always_comb
    begin
        if (s1_advance && s1_is_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_is_end)
        begin
            out_vol_reg  <= vol_stepped;
            out_brt_reg  <= brt_stepped;
            out_vmov_reg <= vol_moved_c;
            out_bmov_reg <= brt_moved_c;
        end
    end

    assign out_valid        = out_valid_reg;
    assign volume_level     = out_vol_reg;
    assign brightness_level = out_brt_reg;
    assign volume_moved     = out_vmov_reg;
    assign brightness_moved = out_bmov_reg;

endmodule
`default_nettype wire

/* sv/hkar_checker.sv */
`default_nettype none
`include "hotkey_autorepeat_level_control_unit_assert.svh"
module hkar_checker
    import hkar_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic [1:0]           operation,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [LEVEL_W-1:0]   volume_level,
    input wire logic [LEVEL_W-1:0]   brightness_level,
    input wire logic                 volume_moved,
    input wire logic                 brightness_moved
);

    logic end_taken;

    assign end_taken = in_valid && in_ready && (operation == OP_POLL_END);

    // a held result keeps its payload
    `HKAR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(volume_level) && $stable(brightness_level)
        && $stable(volume_moved) && $stable(brightness_moved),
        "result changed while stalled")

    // input back-pressure only comes from a stalled result
    `HKAR_ASSERT_SAME(a_stall_cause, !in_ready, out_valid && !out_ready,
        "input stalled without a stalled result")

    // a fresh result must trace back to an accepted poll-end transaction
    `HKAR_ASSERT_SAME(a_result_source, $rose(out_valid), $past(end_taken, 2),
        "result without a poll end")

endmodule

bind hotkey_autorepeat_level_control_unit hkar_checker u_hkar_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .volume_level     (volume_level),
    .brightness_level (brightness_level),
    .volume_moved     (volume_moved),
    .brightness_moved (brightness_moved)
);
`default_nettype wire

/* sim/hotkey_autorepeat_level_control_unit_test.sv */
`timescale 1ns / 100ps

module hotkey_autorepeat_level_control_unit_test;
    import hkar_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 4;
    localparam int SEGMENT_ITEMS = 108;
    localparam int MAX_REPORTED = 10;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] code;
        logic [1:0]       value;
        logic [MS_W-1:0]  ms;
    } hotkey_tx_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] volume;
        logic [LEVEL_W-1:0] brightness;
        logic               volume_moved;
        logic               brightness_moved;
    } level_report_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_COMBO_MODE;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           operation = '0;
    logic [KEY_W-1:0]     key_code = '0;
    logic [1:0]           key_value = '0;
    logic [MS_W-1:0]      time_ms = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [LEVEL_W-1:0]   volume_level;
    logic [LEVEL_W-1:0]   brightness_level;
    logic                 volume_moved;
    logic                 brightness_moved;

    hotkey_autorepeat_level_control_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .key_code         (key_code),
        .key_value        (key_value),
        .time_ms          (time_ms),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .volume_level     (volume_level),
        .brightness_level (brightness_level),
        .volume_moved     (volume_moved),
        .brightness_moved (brightness_moved)
    );

    hotkey_tx_t    pending_hotkey_q[$];
    level_report_t level_report_q[$];
    hotkey_tx_t    held_tx;
    bit            holding = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    int mismatch_count = 0;
    int tx_accepted = 0;
    int reports_checked = 0;
    int settings_loaded = 0;
    int stale_polls = 0;
    logic [MS_W-1:0] stim_ms = '0;

    // Copy of the register file
    logic               cfg_combo = 1'b0;
    logic [KEY_W-1:0]   cfg_mod_key = '0;
    logic [KEY_W-1:0]   cfg_sel_key = '0;
    logic [KEY_W-1:0]   cfg_up_key = '0;
    logic [KEY_W-1:0]   cfg_down_key = '0;
    logic [LEVEL_W-1:0] cfg_vol_ceil = VOLUME_CEILING_RST;
    logic [LEVEL_W-1:0] cfg_brt_ceil = BRIGHTNESS_CEILING_RST;

    // Key tracking and level state
    logic [LEVEL_W-1:0] vol_now = VOLUME_FLOOR;
    logic [LEVEL_W-1:0] brt_now = BRIGHTNESS_FLOOR;
    logic [1:0]         mod_held = '0;
    logic [1:0]         sel_held = '0;
    logic [1:0]         up_held = '0;
    logic [1:0]         up_fresh = '0;
    logic [MS_W-1:0]    up_due = '0;
    logic [1:0]         down_held = '0;
    logic [1:0]         down_fresh = '0;
    logic [MS_W-1:0]    down_due = '0;
    logic [MS_W-1:0]    now_ms = '0;
    logic [MS_W-1:0]    last_poll_ms = '0;
    logic               poll_stale = 1'b0;
    logic               vol_moved = 1'b0;
    logic               brt_moved = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[hotkey_autorepeat_level_control_unit] ERROR");
        $finish;
    end

    function automatic target_t pick_target();
        if (cfg_combo)
        begin
            if (mod_held != 0)
                return TGT_BRIGHTNESS;
            if (sel_held != 0)
                return TGT_VOLUME;
            return TGT_NONE;
        end
        return (mod_held != 0) ? TGT_BRIGHTNESS : TGT_VOLUME;
    endfunction

    task automatic step_level(input logic up);
        case (pick_target())
            TGT_VOLUME:
            begin
                if (up)
                begin
                    if (vol_now < cfg_vol_ceil)
                    begin
                        vol_now = vol_now + 1'b1;
                        vol_moved = 1'b1;
                    end
                end
                else if (vol_now > VOLUME_FLOOR)
                begin
                    vol_now = vol_now - 1'b1;
                    vol_moved = 1'b1;
                end
            end
            TGT_BRIGHTNESS:
            begin
                if (up)
                begin
                    if (brt_now < cfg_brt_ceil)
                    begin
                        brt_now = brt_now + 1'b1;
                        brt_moved = 1'b1;
                    end
                end
                else if (brt_now > BRIGHTNESS_FLOOR)
                begin
                    brt_now = brt_now - 1'b1;
                    brt_moved = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic update_key_levels(input hotkey_tx_t tx);
        level_report_t rpt;
        case (tx.op)
            OP_POLL_START:
            begin
                now_ms = tx.ms;
                if ((now_ms - last_poll_ms) > STALE_GAP_MS)
                    poll_stale = 1'b1;
            end
            OP_KEY_EVENT:
            begin
                if (!poll_stale)
                begin
                    // first match wins: modifier, select (mode 1), up, down
                    if (tx.code == cfg_mod_key)
                        mod_held = tx.value;
                    else if (cfg_combo && tx.code == cfg_sel_key)
                        sel_held = tx.value;
                    else if (tx.code == cfg_up_key)
                    begin
                        up_held = tx.value;
                        up_fresh = tx.value;
                        if (tx.value != 0)
                            up_due = now_ms + FIRST_DELAY_MS;
                    end
                    else if (tx.code == cfg_down_key)
                    begin
                        down_held = tx.value;
                        down_fresh = tx.value;
                        if (tx.value != 0)
                            down_due = now_ms + FIRST_DELAY_MS;
                    end
                end
            end
            OP_POLL_END:
            begin
                if (poll_stale)
                begin
                    mod_held = '0;
                    sel_held = '0;
                    up_held = '0;
                    up_fresh = '0;
                    up_due = '0;
                    down_held = '0;
                    down_fresh = '0;
                    down_due = '0;
                    stale_polls++;
                end
                last_poll_ms = now_ms;
                poll_stale = 1'b0;
                vol_moved = 1'b0;
                brt_moved = 1'b0;
                if (up_fresh != 0 || (up_held != 0 && now_ms >= up_due))
                begin
                    step_level(1'b1);
                    if (up_fresh != 0)
                        up_fresh = '0;
                    else
                        up_due = up_due + REPEAT_MS;
                end
                if (down_fresh != 0 || (down_held != 0 && now_ms >= down_due))
                begin
                    step_level(1'b0);
                    if (down_fresh != 0)
                        down_fresh = '0;
                    else
                        down_due = down_due + REPEAT_MS;
                end
                rpt.volume = vol_now;
                rpt.brightness = brt_now;
                rpt.volume_moved = vol_moved;
                rpt.brightness_moved = brt_moved;
                level_report_q.push_back(rpt);
            end
            default: ;
        endcase
    endtask

    // Driver: one transaction presented at a time, held until accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                update_key_levels(held_tx);
                tx_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_hotkey_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    held_tx = pending_hotkey_q.pop_front();
                    holding = 1'b1;
                    in_valid <= 1'b1;
                    operation <= held_tx.op;
                    key_code <= held_tx.code;
                    key_value <= held_tx.value;
                    time_ms <= held_tx.ms;
                end
                else
                begin
                    holding = 1'b0;
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (level_report_q.size() == 0)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED)
                        $display("unexpected level report: vol %0d brt %0d moved %b%b",
                                 volume_level, brightness_level,
                                 volume_moved, brightness_moved);
                end
                else
                begin
                    level_report_t want;
                    want = level_report_q.pop_front();
                    reports_checked++;
                    if (want.volume !== volume_level || want.brightness !== brightness_level
                        || want.volume_moved !== volume_moved
                        || want.brightness_moved !== brightness_moved)
                    begin
                        error_count++;
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTED)
                            $display({"level mismatch: expected vol %0d brt %0d moved %b%b,",
                                      " got vol %0d brt %0d moved %b%b"},
                                     want.volume, want.brightness,
                                     want.volume_moved, want.brightness_moved,
                                     volume_level, brightness_level,
                                     volume_moved, brightness_moved);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_COMBO_MODE:   cfg_combo = data[0];
            CFG_MODIFIER_KEY: cfg_mod_key = data[KEY_W-1:0];
            CFG_SELECT_KEY:   cfg_sel_key = data[KEY_W-1:0];
            CFG_UP_KEY:       cfg_up_key = data[KEY_W-1:0];
            CFG_DOWN_KEY:     cfg_down_key = data[KEY_W-1:0];
            CFG_VOL_CEILING:  cfg_vol_ceil = data[LEVEL_W-1:0];
            CFG_BRT_CEILING:  cfg_brt_ceil = data[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic mode, input logic [KEY_W-1:0] mod_key,
                                 input logic [KEY_W-1:0] sel_key,
                                 input logic [KEY_W-1:0] up_key,
                                 input logic [KEY_W-1:0] down_key,
                                 input logic [LEVEL_W-1:0] vol_ceil,
                                 input logic [LEVEL_W-1:0] brt_ceil);
        write_reg(CFG_COMBO_MODE, CFG_W'(mode));
        write_reg(CFG_MODIFIER_KEY, CFG_W'(mod_key));
        write_reg(CFG_SELECT_KEY, CFG_W'(sel_key));
        write_reg(CFG_UP_KEY, CFG_W'(up_key));
        write_reg(CFG_DOWN_KEY, CFG_W'(down_key));
        write_reg(CFG_VOL_CEILING, CFG_W'(vol_ceil));
        write_reg(CFG_BRT_CEILING, CFG_W'(brt_ceil));
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_loaded++;
    endtask

    // Wait for every queued transaction and report, then let the pipeline empty
    task automatic drain();
        while (pending_hotkey_q.size() != 0 || holding || level_report_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_tx(input logic [1:0] op, input logic [KEY_W-1:0] code,
                           input logic [1:0] value, input logic [MS_W-1:0] ms);
        hotkey_tx_t tx;
        tx.op = op;
        tx.code = code;
        tx.value = value;
        tx.ms = ms;
        pending_hotkey_q.push_back(tx);
    endtask

    // Unused fields carry noise
    task automatic push_start(input logic [MS_W-1:0] ms);
        push_tx(OP_POLL_START, KEY_W'($urandom_range(0, 767)), 2'($urandom_range(0, 2)), ms);
    endtask

    task automatic push_key(input logic [KEY_W-1:0] code, input logic [1:0] value);
        push_tx(OP_KEY_EVENT, code, value, $urandom);
    endtask

    task automatic push_end();
        push_tx(OP_POLL_END, KEY_W'($urandom_range(0, 767)), 2'($urandom_range(0, 2)),
                $urandom);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0: return cfg_mod_key;
            1: return cfg_sel_key;
            2, 3: return ($urandom_range(0, 1) != 0) ? cfg_up_key : cfg_down_key;
            4: return cfg_down_key;
            default: return KEY_W'($urandom_range(0, 767));
        endcase
    endfunction

    function automatic logic [1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return 2'd0;
        if (r < 80)
            return 2'd1;
        return 2'd2;
    endfunction

    task automatic advance_clock();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            stim_ms = stim_ms + $urandom_range(1001, 4000);
        else if (r < 9)
            stim_ms = stim_ms + STALE_GAP_MS + $urandom_range(0, 1);
        else if (r < 12)
            stim_ms = $urandom;
        else
            stim_ms = stim_ms + $urandom_range(0, 350);
    endtask

    // Mostly complete polls; the rest is stray transactions
    task automatic fill_random(input int target);
        int n;
        int r;
        int nkeys;
        n = 0;
        while (n < target)
        begin
            r = $urandom_range(99);
            if (r < 4)
                push_tx(OP_UNUSED, KEY_W'($urandom_range(0, 767)),
                        2'($urandom_range(0, 2)), $urandom);
            else if (r < 7)
            begin
                push_end();
                n++;
            end
            else if (r < 10)
            begin
                push_key(pick_key(), pick_value());
                n++;
            end
            else if (r < 12)
            begin
                advance_clock();
                push_start(stim_ms);
                n++;
            end
            else
            begin
                advance_clock();
                push_start(stim_ms);
                nkeys = $urandom_range(0, 3);
                for (int k = 0; k < nkeys; k++)
                    push_key(pick_key(), pick_value());
                push_end();
                n += nkeys + 2;
            end
        end
    endtask

    task automatic random_settings(input int flavour);
        logic               md;
        logic [KEY_W-1:0]   km;
        logic [KEY_W-1:0]   ks;
        logic [KEY_W-1:0]   ku;
        logic [KEY_W-1:0]   kd;
        logic [LEVEL_W-1:0] vc;
        logic [LEVEL_W-1:0] bc;
        md = 1'(flavour % 2);
        km = KEY_W'($urandom_range(0, 767));
        ks = KEY_W'($urandom_range(0, 767));
        ku = KEY_W'($urandom_range(0, 767));
        kd = KEY_W'($urandom_range(0, 767));
        vc = LEVEL_W'($urandom_range(0, 255));
        bc = LEVEL_W'($urandom_range(0, 255));
        case (flavour)
            0:
            begin
                vc = 8'd255;
                bc = 8'd255;
            end
            1:
            begin
                vc = 8'd0;
                bc = LEVEL_W'($urandom_range(1, 8));
            end
            2:
            begin
                km = 10'd0;
                ks = 10'd767;
                vc = LEVEL_W'($urandom_range(1, 6));
                bc = LEVEL_W'($urandom_range(1, 6));
            end
            3:
            begin
                kd = ku;
                vc = 8'd5;
                bc = 8'd255;
            end
            4:
            begin
                ku = 10'd767;
                kd = 10'd0;
                vc = LEVEL_W'($urandom_range(1, 4));
                bc = 8'd0;
            end
            default: ks = ku;
        endcase
        load_settings(md, km, ks, ku, kd, vc, bc);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 47;
        // up key shares 767 with select, which mode 0 ignores; ceiling 3 saturates
        load_settings(1'b0, 10'd0, 10'd767, 10'd767, 10'd512, 8'd3, 8'd2);
        push_tx(OP_UNUSED, 10'd767, 2'd2, 32'hFFFF_FFFF);
        push_end();
        push_start(32'd100);
        push_key(10'd767, 2'd1);
        push_key(10'd300, 2'd1);
        push_end();
        push_start(32'd400);
        push_end();
        push_start(32'd500);
        push_key(10'd0, 2'd2);
        push_key(10'd512, 2'd1);
        push_end();
        push_start(32'd1501);
        push_key(10'd767, 2'd1);
        push_end();
        push_start(32'hFFFF_FF00);
        push_end();
        // due time wraps past zero, so the next poll repeats at once
        push_start(32'hFFFF_FF10);
        push_key(10'd767, 2'd1);
        push_end();
        push_start(32'hFFFF_FF80);
        push_end();
        drain();

        // select shadows up in mode 1; volume now sits above its ceiling
        load_settings(1'b1, 10'd100, 10'd767, 10'd767, 10'd0, 8'd1, 8'd0);
        push_start(32'd800);
        push_key(10'd767, 2'd1);
        push_key(10'd0, 2'd1);
        push_end();
        drain();

        stim_ms = 32'd800;
        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    send_idle_pct = 12;
                    recv_idle_pct = 47;
                end
                1:
                begin
                    send_idle_pct = 47;
                    recv_idle_pct = 12;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            random_settings(seg);
            fill_random(SEGMENT_ITEMS);
            drain();
        end

        if (level_report_q.size() != 0)
            error_count++;
        $display("Run covered %0d input transactions and %0d level reports",
                 tx_accepted, reports_checked);
        $display("over %0d register settings; %0d stale polls, %0d mismatches.",
                 settings_loaded, stale_polls, mismatch_count);
        if (error_count == 0)
            $display("[hotkey_autorepeat_level_control_unit] OK");
        else
            $display("[hotkey_autorepeat_level_control_unit] ERROR");
        $finish;
    end

endmodule
